// ----- hdl/line_follower_steering_core_assert.svh -----
// Assertion macros shared by the line follower steering RTL.
`ifndef LINE_FOLLOWER_STEERING_CORE_ASSERT_SVH
`define LINE_FOLLOWER_STEERING_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define LFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define LFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lfs_pkg.sv -----
// Package with types and constants of the line follower steering block.
`default_nettype none
package lfs_pkg;

    // APB address and register index widths
    localparam int LFS_ADDR_W = 5;
    localparam int LFS_RIDX_W = 3;

    // Register indexes
    localparam logic [LFS_RIDX_W-1:0] REG_SPEED_WEIGHTS   = 3'd0;
    localparam logic [LFS_RIDX_W-1:0] REG_ANGLE_WEIGHTS   = 3'd1;
    localparam logic [LFS_RIDX_W-1:0] REG_RISE_LIMIT      = 3'd2;
    localparam logic [LFS_RIDX_W-1:0] REG_SEARCH_DRIVE    = 3'd3;
    localparam logic [LFS_RIDX_W-1:0] REG_RECOVERY_OFFSET = 3'd4;

    localparam logic [3:0] RISE_LIMIT_RST = 4'd15;

    // Divider widths: dividend/quotient and divisor (group bit count 1..4)
    localparam int LFS_DIV_W  = 11;
    localparam int LFS_DVSR_W = 3;

    // Largest drive value: 255 base plus 508 correction
    localparam logic [9:0] LFS_DRIVE_MAX = 10'd763;

    typedef struct packed {
        logic [31:0] speed_weights;
        logic [31:0] angle_weights;
        logic [3:0]  rise_limit;
        logic [7:0]  search_drive;
        logic [7:0]  recovery_offset;
    } t_cfg;

    typedef struct packed {
        logic                  start;
        logic [LFS_DIV_W-1:0]  dividend;
        logic [LFS_DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [LFS_DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BASE,
        ST_MUL,
        ST_CORR,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// ----- hdl/lfs_if.sv -----
// Handshake channel interfaces for sensor requests and drive results.
`default_nettype none
interface lfs_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] sensor_bits;

    modport source (output valid, output op, output sensor_bits, input ready);
    modport sink (input valid, input op, input sensor_bits, output ready);
endinterface

interface lfs_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] left_drive;
    logic [9:0] right_drive;

    modport source (output valid, output left_drive, output right_drive, input ready);
    modport sink (input valid, input left_drive, input right_drive, output ready);
endinterface
`default_nettype wire

// ----- hdl/line_follower_steering_core.sv -----
// Top level of the line follower steering block: sequencer and datapath.
//
//  Port     Dir   Carries
//  i_in     sink  op, sensor_bits (seed or steering tick)
//  o_out    src   left_drive, right_drive
//  psel...  APB   five configuration registers at 4*index
//
// A seed request returns to idle from ST_DECODE; lost-line, straight and
// empty-group ticks go on to ST_OUT, which registers the result; a steering
// tick passes ST_BASE, ST_MUL and ST_CORR before ST_OUT, with two passes of
// the 11-step bit-serial divider (base, then correction).
// Reset (synchronous, active low) clears history, sequencer, presets config.
// The next request is taken while a result waits in the output register;
// a result whose register is still full holds the sequencer until it drains.
`default_nettype none
`include "line_follower_steering_core_assert.svh"
module line_follower_steering_core
    import lfs_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    lfs_in_if.sink                i_in,
    lfs_out_if.source             o_out,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [LFS_ADDR_W-1:0] paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    t_state     r_state, n_state;
    logic       r_op, n_op;
    logic [3:0] r_left, n_left;
    logic [3:0] r_right, n_right;
    logic [3:0] r_prev_l, n_prev_l;
    logic [3:0] r_prev_r, n_prev_r;
    logic       r_last_left, n_last_left;
    logic       r_steer_left, n_steer_left;
    logic [2:0] r_n, n_n;
    logic [9:0] r_asum, n_asum;
    logic [7:0] r_base, n_base;
    logic [9:0] r_res_l, n_res_l;
    logic [9:0] r_res_r, n_res_r;
    logic       r_out_valid, n_out_valid;
    logic [9:0] r_out_l, n_out_l;
    logic [9:0] r_out_r, n_out_r;

    logic        steer_left;
    logic [3:0]  grp;
    logic [3:0]  grp_prev;
    logic [3:0]  grp_f;
    logic [7:0]  inner;
    logic [17:0] prod;
    logic [9:0]  drive_sum;

    // Sum of the 8-bit weights of the set bits of g
    function automatic logic [9:0] weight_sum(input logic [31:0] w, input logic [3:0] g);
        logic [9:0] s;
        s = '0;
        for (int k = 0; k < 4; k++) begin
            if (g[k]) s = s + {2'b00, w[8*k +: 8]};
        end
        return s;
    endfunction

    function automatic logic [2:0] pop4(input logic [3:0] g);
        return {2'b00, g[0]} + {2'b00, g[1]} + {2'b00, g[2]} + {2'b00, g[3]};
    endfunction

    lfs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Pick the steering group and apply the rise filter
    assign steer_left = (r_left > r_right);
    assign grp        = steer_left ? r_left : r_right;
    assign grp_prev   = steer_left ? r_prev_l : r_prev_r;
    assign grp_f      = ({1'b0, grp} > ({1'b0, grp_prev} + {1'b0, cfg.rise_limit}))
                        ? grp_prev : grp;

    // Recovery inner wheel, clamped at zero
    assign inner = (cfg.search_drive > cfg.recovery_offset)
                   ? (cfg.search_drive - cfg.recovery_offset) : 8'd0;

    assign prod      = {8'd0, r_asum} * {10'd0, r_base};
    assign drive_sum = {2'b00, r_base} + {1'b0, div_rsp.quotient[8:0]};

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.left_drive  = r_out_l;
    assign o_out.right_drive = r_out_r;

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_left       = r_left;
        n_right      = r_right;
        n_prev_l     = r_prev_l;
        n_prev_r     = r_prev_r;
        n_last_left  = r_last_left;
        n_steer_left = r_steer_left;
        n_n          = r_n;
        n_asum       = r_asum;
        n_base       = r_base;
        n_res_l      = r_res_l;
        n_res_r      = r_res_r;
        n_out_valid  = r_out_valid;
        n_out_l      = r_out_l;
        n_out_r      = r_out_r;
        div_req      = '0;

        // Drop a result once it is taken
        if (r_out_valid && o_out.ready) n_out_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.op;
                    n_left  = i_in.sensor_bits[7:4];
                    n_right = {i_in.sensor_bits[0], i_in.sensor_bits[1],
                               i_in.sensor_bits[2], i_in.sensor_bits[3]};
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!r_op) begin
                    n_prev_l = r_left;
                    n_prev_r = r_right;
                    n_state  = ST_IDLE;
                end else if (r_left != r_right) begin
                    n_steer_left = steer_left;
                    n_last_left  = steer_left;
                    if (grp_f == 4'd0) begin
                        n_res_l = 10'd0;
                        n_res_r = 10'd0;
                        n_state = ST_OUT;
                    end else begin
                        n_n              = pop4(grp_f);
                        n_asum           = weight_sum(cfg.angle_weights, grp_f);
                        div_req.start    = 1'b1;
                        div_req.dividend = {1'b0, weight_sum(cfg.speed_weights, grp_f)};
                        div_req.divisor  = pop4(grp_f);
                        n_state          = ST_BASE;
                    end
                end else if (r_left == 4'd0) begin
                    n_prev_l = 4'd0;
                    n_prev_r = 4'd0;
                    if (r_last_left) begin
                        n_res_r = {2'b00, cfg.search_drive};
                        n_res_l = {2'b00, inner};
                    end else begin
                        n_res_r = {2'b00, inner};
                        n_res_l = {2'b00, cfg.search_drive};
                    end
                    n_state = ST_OUT;
                end else begin
                    n_res_l = {2'b00, cfg.speed_weights[7:0]};
                    n_res_r = {2'b00, cfg.speed_weights[7:0]};
                    n_state = ST_OUT;
                end
            end
            ST_BASE: begin
                if (div_rsp.done) begin
                    n_base  = div_rsp.quotient[7:0];
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod[17:7];
                div_req.divisor  = r_n;
                n_state          = ST_CORR;
            end
            ST_CORR: begin
                if (div_rsp.done) begin
                    if (r_steer_left) begin
                        n_res_l = drive_sum;
                        n_res_r = {2'b00, r_base};
                    end else begin
                        n_res_l = {2'b00, r_base};
                        n_res_r = drive_sum;
                    end
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_l     = r_res_l;
                    n_out_r     = r_res_r;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev_l    <= 4'd0;
            r_prev_r    <= 4'd0;
            r_last_left <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev_l    <= n_prev_l;
            r_prev_r    <= n_prev_r;
            r_last_left <= n_last_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_left       <= n_left;
        r_right      <= n_right;
        r_steer_left <= n_steer_left;
        r_n          <= n_n;
        r_asum       <= n_asum;
        r_base       <= n_base;
        r_res_l      <= n_res_l;
        r_res_r      <= n_res_r;
        r_out_l      <= n_out_l;
        r_out_r      <= n_out_r;
    end

    `LFS_ASSERT_NOW(a_div_done_in_wait, i_clk, i_rst_n, div_rsp.done,
        (r_state == ST_BASE || r_state == ST_CORR), "divider done outside a wait state")
    `LFS_ASSERT_NOW(a_drive_bound, i_clk, i_rst_n, r_out_valid,
        (r_out_l <= LFS_DRIVE_MAX && r_out_r <= LFS_DRIVE_MAX), "drive value out of range")
    `LFS_ASSERT_NEXT(a_seed_no_result, i_clk, i_rst_n, (r_state == ST_DECODE && !r_op),
        (r_state == ST_IDLE), "seed request did not return to idle")

endmodule
`default_nettype wire

// ----- hdl/lfs_regs.sv -----
// APB configuration register file of the line follower steering block.
`default_nettype none
module lfs_regs
    import lfs_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [LFS_ADDR_W-1:0] paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                  r_cfg;
    t_cfg                  n_cfg;
    logic [LFS_RIDX_W-1:0] ridx;
    logic                  wr_en;

    assign ridx   = paddr[LFS_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Decode writes
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (ridx)
                REG_SPEED_WEIGHTS:   n_cfg.speed_weights   = pwdata;
                REG_ANGLE_WEIGHTS:   n_cfg.angle_weights   = pwdata;
                REG_RISE_LIMIT:      n_cfg.rise_limit      = pwdata[3:0];
                REG_SEARCH_DRIVE:    n_cfg.search_drive    = pwdata[7:0];
                REG_RECOVERY_OFFSET: n_cfg.recovery_offset = pwdata[7:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (ridx)
            REG_SPEED_WEIGHTS:   prdata = r_cfg.speed_weights;
            REG_ANGLE_WEIGHTS:   prdata = r_cfg.angle_weights;
            REG_RISE_LIMIT:      prdata = {28'd0, r_cfg.rise_limit};
            REG_SEARCH_DRIVE:    prdata = {24'd0, r_cfg.search_drive};
            REG_RECOVERY_OFFSET: prdata = {24'd0, r_cfg.recovery_offset};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_weights   <= 32'd0;
            r_cfg.angle_weights   <= 32'd0;
            r_cfg.rise_limit      <= RISE_LIMIT_RST;
            r_cfg.search_drive    <= 8'd0;
            r_cfg.recovery_offset <= 8'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/lfs_div.sv -----
// Shared bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module lfs_div
    import lfs_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(LFS_DIV_W + 1);

    logic                  r_busy;
    logic                  n_busy;
    logic                  r_done;
    logic                  n_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [LFS_DIV_W-1:0]  r_dvd;
    logic [LFS_DIV_W-1:0]  n_dvd;
    logic [LFS_DVSR_W-1:0] r_rem;
    logic [LFS_DVSR_W-1:0] n_rem;
    logic [LFS_DVSR_W-1:0] r_dvsr;
    logic [LFS_DVSR_W-1:0] n_dvsr;
    logic [LFS_DVSR_W:0]   rem_sh;
    logic                  q_bit;

    // Shift in the next dividend bit and try the subtract
    assign rem_sh = {r_rem, r_dvd[LFS_DIV_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_dvsr});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dvsr = r_dvsr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(LFS_DIV_W);
            n_dvd  = i_req.dividend;
            n_rem  = '0;
            n_dvsr = i_req.divisor;
        end else if (r_busy) begin
            n_rem = q_bit ? LFS_DVSR_W'(rem_sh - {1'b0, r_dvsr})
                          : rem_sh[LFS_DVSR_W-1:0];
            n_dvd = {r_dvd[LFS_DIV_W-2:0], q_bit};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_dvsr <= n_dvsr;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd;

endmodule
`default_nettype wire

// ----- tb/sv/lfs_tb_pkg.sv -----
// Request codes and result type shared by the steering testbench files.
`timescale 1ns / 100ps
package lfs_tb_pkg;

    // Request operation carried in the op field
    typedef enum logic {
        OP_SEED = 1'b0,
        OP_TICK = 1'b1
    } t_req_op;

    // One pair of wheel drives as it leaves the block
    typedef struct packed {
        logic [9:0] left_drive;
        logic [9:0] right_drive;
    } t_drive_pair;

endpackage

// ----- tb/sv/line_follower_steering_checker.sv -----
// Checker that predicts wheel drives from sensor requests and compares results.
`timescale 1ns / 100ps
module line_follower_steering_checker
    import lfs_pkg::*;
    import lfs_tb_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    lfs_in_if                    in_ch,
    lfs_out_if                   out_ch,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire                  pready,
    input  wire [LFS_ADDR_W-1:0] paddr,
    input  wire [31:0]           pwdata,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    t_cfg        cfg;
    logic [3:0]  hist_left;
    logic [3:0]  hist_right;
    logic        last_left;
    t_drive_pair drive_queue[$];
    int          fail_count = 0;
    int          checked_count = 0;

    // Print one mismatch line and count it
    task automatic report(input string msg);
        fail_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Work out base speed and angle correction of one sensor group
    task automatic group_drive(input logic [3:0] grp, output int unsigned base,
                               output int unsigned corr);
        int unsigned n;
        int unsigned speed_sum;
        int unsigned angle_sum;
        n = 0;
        speed_sum = 0;
        angle_sum = 0;
        for (int k = 0; k < 4; k++) begin
            if (grp[k]) begin
                n++;
                speed_sum += 32'(cfg.speed_weights[8*k +: 8]);
                angle_sum += 32'(cfg.angle_weights[8*k +: 8]);
            end
        end
        base = (n == 0) ? 0 : speed_sum / n;
        corr = (n == 0) ? 0 : (angle_sum * base) / (128 * n);
    endtask

    // Predict the drives of one steering tick; a lost line clears the history
    task automatic predict_tick(input logic [7:0] bits, output t_drive_pair res);
        logic [3:0]  lgrp;
        logic [3:0]  rgrp;
        int unsigned base;
        int unsigned corr;
        int unsigned inner;
        lgrp = bits[7:4];
        rgrp = {bits[0], bits[1], bits[2], bits[3]};
        if (lgrp > rgrp) begin
            // Hold a left group that jumps too far above its history
            if ({1'b0, lgrp} > {1'b0, hist_left} + {1'b0, cfg.rise_limit})
                lgrp = hist_left;
            group_drive(lgrp, base, corr);
            res.left_drive  = 10'(base + corr);
            res.right_drive = 10'(base);
            last_left = 1'b1;
        end else if (rgrp > lgrp) begin
            if ({1'b0, rgrp} > {1'b0, hist_right} + {1'b0, cfg.rise_limit})
                rgrp = hist_right;
            group_drive(rgrp, base, corr);
            res.right_drive = 10'(base + corr);
            res.left_drive  = 10'(base);
            last_left = 1'b0;
        end else if (bits == 8'h00) begin
            // Line lost: turn back toward the last steering side, clamp the inner wheel
            inner = (cfg.search_drive > cfg.recovery_offset) ?
                    32'(cfg.search_drive - cfg.recovery_offset) : 0;
            if (last_left) begin
                res.right_drive = 10'(cfg.search_drive);
                res.left_drive  = 10'(inner);
            end else begin
                res.left_drive  = 10'(cfg.search_drive);
                res.right_drive = 10'(inner);
            end
            hist_left  = 4'h0;
            hist_right = 4'h0;
        end else begin
            res.left_drive  = {2'b00, cfg.speed_weights[7:0]};
            res.right_drive = {2'b00, cfg.speed_weights[7:0]};
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_drive_pair want;
        if (!i_rst_n) begin
            cfg = '0;
            cfg.rise_limit = RISE_LIMIT_RST;
            hist_left  = 4'h0;
            hist_right = 4'h0;
            last_left  = 1'b0;
            drive_queue.delete();
        end else begin
            // Compare a drained result with the oldest expectation
            if (out_ch.valid && out_ch.ready) begin
                if (drive_queue.size() == 0) begin
                    report($sformatf("drive result with nothing pending: left %0d right %0d",
                                     out_ch.left_drive, out_ch.right_drive));
                end else begin
                    want = drive_queue.pop_front();
                    checked_count++;
                    if (out_ch.left_drive !== want.left_drive)
                        report($sformatf("left_drive expected %0d, got %0d",
                                         want.left_drive, out_ch.left_drive));
                    if (out_ch.right_drive !== want.right_drive)
                        report($sformatf("right_drive expected %0d, got %0d",
                                         want.right_drive, out_ch.right_drive));
                end
            end

            // Predict the outcome of an accepted request
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.op == OP_SEED) begin
                    hist_left  = in_ch.sensor_bits[7:4];
                    hist_right = {in_ch.sensor_bits[0], in_ch.sensor_bits[1],
                                  in_ch.sensor_bits[2], in_ch.sensor_bits[3]};
                end else begin
                    predict_tick(in_ch.sensor_bits, want);
                    drive_queue.push_back(want);
                end
            end

            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[LFS_ADDR_W-1:2])
                    REG_SPEED_WEIGHTS:   cfg.speed_weights   = pwdata;
                    REG_ANGLE_WEIGHTS:   cfg.angle_weights   = pwdata;
                    REG_RISE_LIMIT:      cfg.rise_limit      = pwdata[3:0];
                    REG_SEARCH_DRIVE:    cfg.search_drive    = pwdata[7:0];
                    REG_RECOVERY_OFFSET: cfg.recovery_offset = pwdata[7:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= drive_queue.size();
        o_checked    <= checked_count;
    end

endmodule

// ----- tb/sv/line_follower_steering_core_tb.sv -----
// Top of the steering testbench: clock, reset, register writes and sensor traffic.
`timescale 1ns / 100ps
module line_follower_steering_core_tb;
    import lfs_pkg::*;
    import lfs_tb_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [LFS_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    lfs_in_if  in_if();
    lfs_out_if out_if();

    int fail_count;
    int pending_count;
    int checked_count;
    bit idle_on;
    int stall_left;
    int n_ticks = 0;
    int n_seeds = 0;
    int n_writes = 0;
    int n_settings = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    line_follower_steering_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    line_follower_steering_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_if),
        .out_ch       (out_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Byte whose left and right groups read the same value
    function automatic logic [7:0] mirror_pair(input logic [3:0] g);
        return {g, g[0], g[1], g[2], g[3]};
    endfunction

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            out_if.ready <= 1'b0;
            stall_left = idle_len() - 1;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Write one register: setup phase, access phase, then idle with psel low
    task automatic reg_write(input logic [LFS_RIDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] speeds, input logic [31:0] angles,
                              input logic [3:0] thresh, input logic [7:0] rec_speed,
                              input logic [7:0] rec_offset);
        reg_write(REG_SPEED_WEIGHTS, speeds);
        reg_write(REG_ANGLE_WEIGHTS, angles);
        reg_write(REG_RISE_LIMIT, {28'h0, thresh});
        reg_write(REG_SEARCH_DRIVE, {24'h0, rec_speed});
        reg_write(REG_RECOVERY_OFFSET, {24'h0, rec_offset});
        n_settings++;
    endtask

    // Offer one sensor request after a random gap and hold it until taken
    task automatic send_request(input t_req_op op, input logic [7:0] bits);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.op          <= op;
        in_if.sensor_bits <= bits;
        do @(posedge i_clk); while (!in_if.ready);
        if (op == OP_TICK)
            n_ticks++;
        else
            n_seeds++;
    endtask

    // Drop valid, wait for every pending drive, then let a seed settle
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        in_if.valid       = 1'b0;
        in_if.op          = OP_SEED;
        in_if.sensor_bits = 8'h00;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = 32'h0;
        i_rst_n           = 1'b0;
        idle_on           = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each steering case under moderate weights
        set_config(32'h40302010, 32'h80604020, 4'd15, 8'd200, 8'd50);
        send_request(OP_TICK, 8'h00);         // line lost before any turn
        send_request(OP_TICK, 8'hF0);         // full left group
        send_request(OP_TICK, 8'h00);         // line lost after a left turn
        send_request(OP_TICK, 8'h0F);         // full right group
        send_request(OP_TICK, 8'h80);
        send_request(OP_TICK, 8'h01);         // single right bit reads as 8
        send_request(OP_TICK, 8'hFF);         // straight
        send_request(OP_TICK, mirror_pair(4'h1));
        send_request(OP_TICK, 8'h8F);
        send_request(OP_SEED, 8'hA5);
        send_request(OP_TICK, 8'h5A);
        drain();

        // Directed: zero threshold, full weights, inner wheel clamped
        set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 4'd0, 8'd10, 8'd255);
        send_request(OP_SEED, 8'h30);
        send_request(OP_TICK, 8'hF0);         // jump held at history
        send_request(OP_TICK, 8'h20);         // fall passes unfiltered
        send_request(OP_TICK, 8'h0F);         // held to an empty group
        send_request(OP_TICK, 8'h00);         // clamp and clear history
        send_request(OP_SEED, 8'hFF);
        send_request(OP_TICK, 8'hF0);         // largest drive
        send_request(OP_TICK, 8'h0F);
        send_request(OP_TICK, 8'h00);
        send_request(OP_TICK, 8'hF0);         // history cleared by lost line
        drain();

        // Random phases, each under its own register setting
        for (int phase = 0; phase < 8; phase++) begin
            idle_on = (phase % 3 != 2);
            case (phase)
                0: set_config(32'h0, 32'h0, 4'd0, 8'd0, 8'd0);
                1: set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15, 8'd255, 8'd0);
                2: set_config($urandom, $urandom, 4'd1, 8'd0, 8'd255);
                default: set_config($urandom, $urandom, 4'($urandom_range(0, 15)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            for (int i = 0; i < 160; i++) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 15)
                    send_request(OP_SEED, 8'($urandom_range(0, 255)));
                else if (r < 25)
                    send_request(OP_TICK, 8'h00);
                else if (r < 35)
                    send_request(OP_TICK, mirror_pair(4'($urandom_range(0, 15))));
                else if (r < 45)
                    send_request(OP_TICK, {4'($urandom_range(0, 15)), 4'h0});
                else if (r < 55)
                    send_request(OP_TICK, {4'h0, 4'($urandom_range(0, 15))});
                else
                    send_request(OP_TICK, 8'($urandom_range(0, 255)));
            end
            drain();
        end

        $display("Covered %0d steering ticks and %0d seed requests under %0d settings",
                 n_ticks, n_seeds, n_settings);
        $display("(%0d register writes); %0d drive results compared.", n_writes, checked_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(12_000_000);
        $display("Timeout: drive results still pending");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
